FILE: sv/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

  // Default number of slots the bitmap can track.
  localparam int MAX_SLOTS_DEF = 1024;

  // The bitmap is stored as words of this many slot bits.
  localparam int WORD_W = 32;
  localparam int OFF_W  = 5;

  localparam int STAT_W = 3;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK           = 3'd0;
  localparam logic [STAT_W-1:0] STAT_NO_FREE      = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO_COUNT   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_ALREADY_FREE = 3'd3;
  localparam logic [STAT_W-1:0] STAT_SEARCH_FAIL  = 3'd4;

  localparam logic REG_SLOTS_IN_USE   = 1'b0;
  localparam logic REG_RESERVED_SLOTS = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_CHECK,
    S_SCAN
  } st_t;

endpackage

`default_nettype wire

FILE: sv/bitmap_slot_allocator.sv
`default_nettype none

// Bitmap slot allocator with next-fit placement and a lowest-free fallback.
// A command beat is taken when start is high and busy is low. With in_action
// at allocate, the block grants the slot after the last one it granted
// (wrapping at the managed slot count); if that slot is taken it hands out
// the lowest free slot instead. With in_action at free, in_slot_index is
// released. Every command produces exactly one result beat, shown for one
// cycle with out_strobe high; the receiver cannot hold it off.
// A refused command answers with a registered beat straight from idle; a
// normal allocate or free first reads its bitmap word, then answers from
// the check state. When the stored last slot lies at or beyond the managed
// count, its wrap first goes through a bit-serial remainder unit. A fallback
// search reads one 32-slot bitmap word per cycle from the bitmap memory,
// from word 0 up to the first word with a free slot or the word holding the
// highest managed slot. Busy is low in the cycle the result beat is shown,
// so the next command can be taken at the edge that ends it.
// The bitmap lives in one RAM with a registered read; every item is a
// read-modify-write on one word, and items run one at a time.
// After reset the block sweeps the RAM clear, one word per cycle, with
// busy high; configuration writes are taken at any time but must only
// change while the block is idle.
module bitmap_slot_allocator
  import bsa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  localparam int SLOT_W = $clog2(MAX_SLOTS),
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CNT_W-1:0]  cfg_data,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              in_action,
  input  wire logic [SLOT_W-1:0] in_slot_index,
  output logic                   out_strobe,
  output logic      [STAT_W-1:0] out_status,
  output logic      [SLOT_W-1:0] out_granted_slot,
  output logic      [CNT_W-1:0]  out_used_count
);

  localparam int WORDS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int SX_W   = SLOT_W + OFF_W;

  // Control state.
  st_t               state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [CNT_W-1:0]  slots_cfg_r;
  logic [CNT_W-1:0]  resv_cfg_r;
  logic [SLOT_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0]  in_use_r, in_use_nxt;
  logic              out_strobe_r, out_strobe_nxt;

  // Per-item payload.
  logic              act_r, act_nxt;
  logic [SLOT_W-1:0] cand_r, cand_nxt;
  logic [ADDR_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_granted_r, out_granted_nxt;
  logic [CNT_W-1:0]  out_used_r, out_used_nxt;

  // Bitmap memory ports.
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // Remainder unit.
  logic              mod_start;
  logic              mod_done;
  logic [CNT_W-1:0]  mod_rem;

  // Decoded item conditions.
  logic              accept;
  logic [CNT_W-1:0]  n_slots;
  logic [CNT_W-1:0]  cap;
  logic              no_free;
  logic [CNT_W-1:0]  next_v;
  logic              next_lt;
  logic              next_eq;
  logic              idx_oob;
  logic [SLOT_W-1:0] n_m1;
  logic [SX_W-1:0]   n_m1_sx;
  logic [ADDR_W-1:0] last_word;
  logic [OFF_W-1:0]  last_bit;

  logic [SX_W-1:0]   cand_sx;
  logic [SX_W-1:0]   idx_sx;
  logic [SX_W-1:0]   next_sx;
  logic [SX_W-1:0]   rem_sx;
  logic [OFF_W-1:0]  cand_off;
  logic              cand_used;

  logic [WORD_W-1:0] scan_mask;
  logic [WORD_W-1:0] scan_free;
  logic              scan_hit;
  logic [OFF_W-1:0]  scan_pos;
  logic [SLOT_W-1:0] scan_slot;
  logic              scan_end;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Managed count is clamped to 1..MAX_SLOTS; capacity is what the reserve leaves.
  always_comb begin
    n_slots = slots_cfg_r;
    if (slots_cfg_r == '0) begin
      n_slots = CNT_W'(1);
    end else if (slots_cfg_r > CNT_W'(MAX_SLOTS)) begin
      n_slots = CNT_W'(MAX_SLOTS);
    end
  end

  assign cap     = (n_slots > resv_cfg_r) ? (n_slots - resv_cfg_r) : '0;
  assign no_free = (in_use_r >= cap);
  assign next_v  = CNT_W'(last_r) + CNT_W'(1);
  assign next_lt = (next_v < n_slots);
  assign next_eq = (next_v == n_slots);
  assign idx_oob = (CNT_W'(in_slot_index) >= CNT_W'(MAX_SLOTS));

  // The search stops at the word holding the highest managed slot, and only
  // looks at bits below the managed count in that word.
  assign n_m1      = SLOT_W'(n_slots - CNT_W'(1));
  assign n_m1_sx   = SX_W'(n_m1);
  assign last_word = n_m1_sx[ADDR_W+OFF_W-1:OFF_W];
  assign last_bit  = n_m1_sx[OFF_W-1:0];

  assign cand_sx   = SX_W'(cand_r);
  assign idx_sx    = SX_W'(in_slot_index);
  assign next_sx   = SX_W'(SLOT_W'(next_v));
  assign rem_sx    = SX_W'(SLOT_W'(mod_rem));
  assign cand_off  = cand_sx[OFF_W-1:0];
  assign cand_used = mem_rdata[cand_off];

  assign scan_mask = (scan_addr_r == last_word) ?
                     ({WORD_W{1'b1}} >> (OFF_W'(WORD_W - 1) - last_bit)) :
                     {WORD_W{1'b1}};
  assign scan_free = ~mem_rdata & scan_mask;
  assign scan_hit  = |scan_free;
  assign scan_end  = (scan_addr_r == last_word);

  always_comb begin
    scan_pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (scan_free[i]) begin
        scan_pos = OFF_W'(i);
      end
    end
  end

  assign scan_slot = SLOT_W'({scan_addr_r, scan_pos});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == ADDR_W'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_ALLOC) begin
            if (!no_free) begin
              state_nxt = (next_lt || next_eq) ? S_CHECK : S_MOD;
            end
          end else if ((in_use_r != '0) && !idx_oob) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((act_r == ACT_ALLOC) && cand_used) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Datapath, memory controls and result.
  always_comb begin
    last_nxt        = last_r;
    in_use_nxt      = in_use_r;
    act_nxt         = act_r;
    cand_nxt        = cand_r;
    scan_addr_nxt   = scan_addr_r;
    out_strobe_nxt  = 1'b0;
    out_status_nxt  = out_status_r;
    out_granted_nxt = out_granted_r;
    out_used_nxt    = out_used_r;
    mem_we          = 1'b0;
    mem_waddr       = cand_sx[ADDR_W+OFF_W-1:OFF_W];
    mem_wdata       = mem_rdata;
    mem_raddr       = scan_addr_r + ADDR_W'(1);
    mod_start       = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_action;
          if (in_action == ACT_ALLOC) begin
            cand_nxt  = next_lt ? SLOT_W'(next_v) : '0;
            mem_raddr = next_lt ? next_sx[ADDR_W+OFF_W-1:OFF_W] : '0;
            if (no_free) begin
              out_strobe_nxt  = 1'b1;
              out_status_nxt  = STAT_NO_FREE;
              out_granted_nxt = '0;
              out_used_nxt    = in_use_r;
            end else if (!next_lt && !next_eq) begin
              mod_start = 1'b1;
            end
          end else begin
            cand_nxt  = in_slot_index;
            mem_raddr = idx_sx[ADDR_W+OFF_W-1:OFF_W];
            if (in_use_r == '0) begin
              out_strobe_nxt  = 1'b1;
              out_status_nxt  = STAT_ZERO_COUNT;
              out_granted_nxt = '0;
              out_used_nxt    = in_use_r;
            end else if (idx_oob) begin
              out_strobe_nxt  = 1'b1;
              out_status_nxt  = STAT_ALREADY_FREE;
              out_granted_nxt = '0;
              out_used_nxt    = in_use_r;
            end
          end
        end
      end
      S_MOD: begin
        cand_nxt  = SLOT_W'(mod_rem);
        mem_raddr = rem_sx[ADDR_W+OFF_W-1:OFF_W];
      end
      S_CHECK: begin
        mem_raddr = '0;
        if (act_r == ACT_ALLOC) begin
          if (!cand_used) begin
            mem_we          = 1'b1;
            mem_wdata       = mem_rdata | (WORD_W'(1) << cand_off);
            last_nxt        = cand_r;
            in_use_nxt      = in_use_r + CNT_W'(1);
            out_strobe_nxt  = 1'b1;
            out_status_nxt  = STAT_OK;
            out_granted_nxt = cand_r;
            out_used_nxt    = in_use_r + CNT_W'(1);
          end else begin
            scan_addr_nxt = '0;
          end
        end else begin
          out_strobe_nxt  = 1'b1;
          out_granted_nxt = '0;
          if (cand_used) begin
            mem_we         = 1'b1;
            mem_wdata      = mem_rdata & ~(WORD_W'(1) << cand_off);
            in_use_nxt     = in_use_r - CNT_W'(1);
            out_status_nxt = STAT_OK;
            out_used_nxt   = in_use_r - CNT_W'(1);
          end else begin
            out_status_nxt = STAT_ALREADY_FREE;
            out_used_nxt   = in_use_r;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          mem_we          = 1'b1;
          mem_waddr       = scan_addr_r;
          mem_wdata       = mem_rdata | (WORD_W'(1) << scan_pos);
          last_nxt        = scan_slot;
          in_use_nxt      = in_use_r + CNT_W'(1);
          out_strobe_nxt  = 1'b1;
          out_status_nxt  = STAT_OK;
          out_granted_nxt = scan_slot;
          out_used_nxt    = in_use_r + CNT_W'(1);
        end else if (scan_end) begin
          // Map and counter disagree: nothing free below the managed count.
          out_strobe_nxt  = 1'b1;
          out_status_nxt  = STAT_SEARCH_FAIL;
          out_granted_nxt = '0;
          out_used_nxt    = in_use_r;
        end else begin
          scan_addr_nxt = scan_addr_r + ADDR_W'(1);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      slots_cfg_r  <= CNT_W'(MAX_SLOTS);
      resv_cfg_r   <= '0;
      last_r       <= '0;
      in_use_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      last_r       <= last_nxt;
      in_use_r     <= in_use_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_SLOTS_IN_USE:   slots_cfg_r <= cfg_data;
          REG_RESERVED_SLOTS: resv_cfg_r  <= cfg_data;
          default:            resv_cfg_r  <= resv_cfg_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    cand_r        <= cand_nxt;
    scan_addr_r   <= scan_addr_nxt;
    out_status_r  <= out_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_used_r    <= out_used_nxt;
  end

  bsa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(WORDS)
  ) u_map_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bsa_mod #(
    .W(CNT_W)
  ) u_wrap_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(next_v),
    .divisor (n_slots),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_granted_slot = out_granted_r;
  assign out_used_count   = out_used_r;

endmodule

`default_nettype wire

FILE: sv/bsa_ram.sv
`default_nettype none

module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/bsa_mod.sv
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle; done pulses once all
// W dividend bits are in, with rem valid in that cycle.
module bsa_mod #(
  parameter int W = 11
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic      [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  dvd_r;
  logic [W-1:0]  dsr_r;

  logic [W:0] trial;
  logic [W:0] diff;
  logic [W-1:0] rem_nxt;

  assign trial   = {rem_r, dvd_r[W-1]};
  assign diff    = trial - {1'b0, dsr_r};
  assign rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[W-1:0] : trial[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb
  import bsa_pkg::*;
;

  // The block is used at its default size: 1024 slots, 10-bit slot numbers
  // and an 11-bit count that can reach 1024.
  localparam int MAX_SLOTS = MAX_SLOTS_DEF;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

  // One result beat as the block should report it.
  typedef struct {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] granted;
    logic [CNT_W-1:0]  count;
  } slot_reply_t;

  // The class keeps its own copy of the slot bitmap, the last granted slot,
  // the in-use count and both registers. Every accepted command beat is run
  // through that copy to work out the reply, which then waits in a queue
  // until the block's reply beat shows up.
  class slot_book;
    bit [MAX_SLOTS-1:0] taken;
    int unsigned        last_slot;
    int unsigned        held;
    int unsigned        slot_limit;
    int unsigned        held_back;
    slot_reply_t        awaited_replies[$];
    int                 errors;
    int                 commands;
    int                 grants;
    int                 fallback_grants;
    int                 stale_wraps;
    int                 refusals;
    int                 frees;
    int                 empty_frees;
    int                 idle_frees;
    int                 failed_searches;

    function new();
      taken           = '0;
      last_slot       = 0;
      held            = 0;
      slot_limit      = MAX_SLOTS;
      held_back       = 0;
      errors          = 0;
      commands        = 0;
      grants          = 0;
      fallback_grants = 0;
      stale_wraps     = 0;
      refusals        = 0;
      frees           = 0;
      empty_frees     = 0;
      idle_frees      = 0;
      failed_searches = 0;
    endfunction

    function void write_reg(logic index, logic [CNT_W-1:0] value);
      if (index == REG_SLOTS_IN_USE) begin
        slot_limit = 32'(value);
      end else begin
        held_back = 32'(value);
      end
    endfunction

    // A count of zero behaves as one, and anything above the bitmap size is
    // clipped to the bitmap size.
    function int unsigned managed_slots();
      int unsigned n;
      n = slot_limit;
      if (n == 0) begin
        n = 1;
      end
      if (n > MAX_SLOTS) begin
        n = MAX_SLOTS;
      end
      return n;
    endfunction

    function void log_command(logic action, logic [SLOT_W-1:0] index);
      slot_reply_t  reply;
      int unsigned  n;
      int unsigned  capacity;
      int unsigned  candidate;
      bit           found;
      reply.status  = STAT_OK;
      reply.granted = '0;
      commands++;
      if (action == ACT_ALLOC) begin
        n        = managed_slots();
        capacity = (n > held_back) ? n - held_back : 0;
        if (held >= capacity) begin
          reply.status = STAT_NO_FREE;
          refusals++;
        end else begin
          if (last_slot >= n) begin
            stale_wraps++;
          end
          candidate = (last_slot + 1) % n;
          found     = 1'b1;
          if (taken[candidate]) begin
            // Next-fit slot is busy, so fall back to the lowest free slot
            // below the managed count.
            found = 1'b0;
            for (int unsigned i = 0; i < n; i++) begin
              if (!taken[i]) begin
                candidate = i;
                found     = 1'b1;
                break;
              end
            end
            if (found) begin
              fallback_grants++;
            end
          end
          if (!found) begin
            reply.status = STAT_SEARCH_FAIL;
            failed_searches++;
          end else begin
            taken[candidate] = 1'b1;
            last_slot        = candidate;
            held++;
            reply.granted    = candidate[SLOT_W-1:0];
            grants++;
          end
        end
      end else begin
        if (held == 0) begin
          reply.status = STAT_ZERO_COUNT;
          empty_frees++;
        end else if (!taken[index]) begin
          reply.status = STAT_ALREADY_FREE;
          idle_frees++;
        end else begin
          taken[index] = 1'b0;
          held--;
          frees++;
        end
      end
      reply.count = held[CNT_W-1:0];
      awaited_replies.push_back(reply);
    endfunction

    function void match_reply(logic [STAT_W-1:0] status, logic [SLOT_W-1:0] granted,
                              logic [CNT_W-1:0] count);
      slot_reply_t want;
      if (awaited_replies.size() == 0) begin
        $error("reply beat with no command outstanding: status %0d slot %0d count %0d",
               status, granted, count);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (granted !== want.granted) begin
        $error("granted_slot: expected %0d, got %0d", want.granted, granted);
        errors++;
      end
      if (count !== want.count) begin
        $error("used_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_replies.size();
    endfunction

    // Finds some slot that is currently held, starting the search at a
    // random point so that frees land all over the map.
    function bit pick_held(output logic [SLOT_W-1:0] slot);
      int unsigned origin;
      int unsigned probe;
      origin = $urandom_range(MAX_SLOTS - 1, 0);
      slot   = '0;
      for (int unsigned k = 0; k < MAX_SLOTS; k++) begin
        probe = (origin + k) % MAX_SLOTS;
        if (taken[probe]) begin
          slot = probe[SLOT_W-1:0];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

  // Every input is at a known value from time zero, and reset is held low.
  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              cfg_we        = 1'b0;
  logic              cfg_index     = REG_SLOTS_IN_USE;
  logic [CNT_W-1:0]  cfg_data      = '0;
  logic              start         = 1'b0;
  logic              in_action     = ACT_ALLOC;
  logic [SLOT_W-1:0] in_slot_index = '0;
  logic              busy;
  logic              out_strobe;
  logic [STAT_W-1:0] out_status;
  logic [SLOT_W-1:0] out_granted_slot;
  logic [CNT_W-1:0]  out_used_count;

  slot_book book;

  bitmap_slot_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_slot_index    (in_slot_index),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_granted_slot (out_granted_slot),
    .out_used_count   (out_used_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Reply beats last one cycle and cannot be held off, so every strobe seen
  // at a rising edge is checked right there against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      book.match_reply(out_status, out_granted_slot, out_used_count);
    end
  end

  // Presents one command beat. It is entered just after a falling edge and
  // returns at a falling edge with start still high, so a following beat can
  // go out back to back. The beat is taken at the first rising edge where
  // busy is low; only then does the prediction run.
  task automatic send_command(input logic action, input logic [SLOT_W-1:0] index);
    start         = 1'b1;
    in_action     = action;
    in_slot_index = index;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    book.log_command(action, index);
    @(negedge clk);
  endtask

  // Drops start for a number of cycles and puts noise on the command fields,
  // which the block must ignore while start is low.
  task automatic hold_off(input int cycles);
    start         = 1'b0;
    in_action     = 1'($urandom_range(1, 0));
    in_slot_index = SLOT_W'($urandom_range(MAX_SLOTS - 1, 0));
    repeat (cycles) begin
      @(negedge clk);
    end
  endtask

  // Stops sending until every predicted reply has come back.
  task automatic drain();
    start = 1'b0;
    while (book.outstanding() != 0) begin
      @(negedge clk);
    end
  endtask

  // Registers may only change while the block is idle: all replies are in
  // and busy has dropped, which also covers the clearing sweep after reset.
  task automatic set_regs(input logic [CNT_W-1:0] slots, input logic [CNT_W-1:0] spare);
    drain();
    while (busy) begin
      @(negedge clk);
    end
    cfg_we    = 1'b1;
    cfg_index = REG_SLOTS_IN_USE;
    cfg_data  = slots;
    book.write_reg(REG_SLOTS_IN_USE, slots);
    @(negedge clk);
    cfg_index = REG_RESERVED_SLOTS;
    cfg_data  = spare;
    book.write_reg(REG_RESERVED_SLOTS, spare);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random traffic for one register setting. Allocates come with a random
  // slot number that the block must ignore. Most frees target a slot that is
  // actually held; the rest use any slot number, which mostly hits free
  // slots. Commands go out in bursts with random gaps, now and then the
  // sender waits for every reply, and some phases run with no gaps at all.
  task automatic run_phase(input int beats, input int alloc_pct, input bit back_to_back);
    int               left;
    int               burst;
    int               pick;
    logic             action;
    logic [SLOT_W-1:0] index;
    left = beats;
    while (left > 0) begin
      burst = $urandom_range(16, 1);
      for (int b = 0; b < burst && left > 0; b++) begin
        if ($urandom_range(99, 0) < alloc_pct) begin
          action = ACT_ALLOC;
          index  = SLOT_W'($urandom_range(MAX_SLOTS - 1, 0));
        end else begin
          action = ACT_FREE;
          if ($urandom_range(3, 0) == 0 || !book.pick_held(index)) begin
            index = SLOT_W'($urandom_range(MAX_SLOTS - 1, 0));
          end
        end
        send_command(action, index);
        left--;
      end
      if (!back_to_back) begin
        pick = $urandom_range(19, 0);
        if (pick == 0) begin
          drain();
        end else if (pick > 6) begin
          hold_off($urandom_range(12, 1));
        end
      end
    end
  endtask

  // Register settings for the random part: managed slot count, reserved
  // slots, number of commands and the share of allocates in percent. Small
  // counts fill up quickly, so refusals, next-fit collisions and the
  // lowest-free search come often. The large phase leaves many low slots
  // held, so the smaller count after it starts with a stale last slot and
  // long searches. A reserve at or above the count shuts allocation off.
  localparam int PHASES = 12;
  localparam int PHASE_SLOTS [PHASES] = '{8, 1, 33, 0, 64, 900, 256, 2047, 100, 32, 1024, 40};
  localparam int PHASE_SPARE [PHASES] = '{0, 0, 5, 0, 70, 0, 0, 1000, 3, 0, 1024, 0};
  localparam int PHASE_BEATS [PHASES] =
    '{150, 60, 150, 40, 60, 300, 200, 120, 200, 170, 50, 150};
  localparam int PHASE_ALLOC [PHASES] = '{60, 60, 65, 50, 50, 92, 55, 50, 60, 55, 50, 50};

  initial begin
    book = new();
    repeat (8) begin
      @(negedge clk);
    end
    rst_n = 1'b1;

    // Directed part, starting from the reset setting of 1024 slots and no
    // reserve. A free with nothing held, two grants from the slot after the
    // reset value, frees of free slots at both ends of the index range and a
    // normal free.
    set_regs(11'd1024, 11'd0);
    send_command(ACT_FREE, 10'd5);
    send_command(ACT_ALLOC, '0);
    send_command(ACT_ALLOC, '1);
    send_command(ACT_FREE, '1);
    send_command(ACT_FREE, '0);
    send_command(ACT_FREE, 10'd2);
    send_command(ACT_ALLOC, 10'd77);

    // Four slots: the next fit wraps to slot 0, then collides and falls back
    // to the lowest free slot, then the map is full.
    set_regs(11'd4, 11'd0);
    send_command(ACT_ALLOC, '0);
    send_command(ACT_ALLOC, '0);
    send_command(ACT_ALLOC, '0);
    send_command(ACT_FREE, 10'd3);

    // A count of zero behaves as one slot.
    set_regs(11'd0, 11'd0);
    send_command(ACT_ALLOC, '0);

    // Count above the bitmap size with reserves that leave no room, then
    // just enough room for one more grant.
    set_regs(11'd2047, 11'd2047);
    send_command(ACT_ALLOC, '0);
    set_regs(11'd2047, 11'd1021);
    send_command(ACT_ALLOC, '0);
    set_regs(11'd2047, 11'd1020);
    send_command(ACT_ALLOC, '0);

    // Fill a few more slots, then lower the count below the held slots. The
    // allocate is refused since the count of held slots already reaches the
    // new limit. Frees above the managed count are still honored, and the
    // next allocate wraps a stale last slot and has to search.
    set_regs(11'd16, 11'd0);
    repeat (4) begin
      send_command(ACT_ALLOC, '0);
    end
    set_regs(11'd6, 11'd0);
    send_command(ACT_ALLOC, '0);
    send_command(ACT_FREE, 10'd7);
    send_command(ACT_FREE, 10'd6);
    send_command(ACT_FREE, 10'd5);
    send_command(ACT_FREE, 10'd4);
    send_command(ACT_ALLOC, '0);

    // Random part, one phase per register setting.
    for (int p = 0; p < PHASES; p++) begin
      set_regs(PHASE_SLOTS[p][CNT_W-1:0], PHASE_SPARE[p][CNT_W-1:0]);
      run_phase(PHASE_BEATS[p], PHASE_ALLOC[p], (p % 4) == 1);
    end

    // Wait for the last replies, then a little longer so that a stray beat
    // would still be caught.
    drain();
    repeat (20) begin
      @(negedge clk);
    end

    $display("Ran %0d commands: %0d grants (%0d by lowest-free search, %0d stale wraps),",
             book.commands, book.grants, book.fallback_grants, book.stale_wraps);
    $display("  %0d refused, %0d frees, %0d frees with none held, %0d frees of free slots.",
             book.refusals, book.frees, book.empty_frees, book.idle_frees);
    if (book.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // A correct run takes well under a fifth of this, even with every command
  // paying for a stale wrap and a full search after the longest gap.
  initial begin
    #(5_000_000);
    $error("run did not finish in time, %0d replies outstanding", book.outstanding());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
sv/bsa_pkg.sv
sv/bsa_ram.sv
sv/bsa_mod.sv
sv/bitmap_slot_allocator.sv
test/tb.sv
